// ----- rtl/core/lrupr_pkg.sv -----
`timescale 1ns / 1ps
package lrupr_pkg;

  // build-time defaults
  localparam int MAX_FRAMES_DEF = 16;
  localparam int PAGE_BITS_DEF  = 16;

  // fixed field widths
  localparam int PAGE_ID_W    = 16;
  localparam int FRAME_USED_W = 4;
  localparam int FAULT_W      = 32;

  // configuration register
  localparam int          CFG_W           = 5;
  localparam logic [4:0]  CFG_FRAMES_RST  = 5'd4;
  localparam int          APB_ADDR_W      = 3;
  localparam int          APB_DATA_W      = 32;
  localparam logic        REG_FRAMES_IN_USE = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_UPD
  } lrupr_state_t;

  typedef struct packed {
    logic capture;
    logic decide;
    logic commit;
  } lrupr_cmd_t;

endpackage

// ----- rtl/core/lru_page_replacement_unit.sv -----
`timescale 1ns / 1ps
// channel | handshake                     | payload
// --------+-------------------------------+---------------------------------------------------
// input   | in_valid / in_stall           | in_page_id, in_last_ref
// result  | out_valid / out_stall         | out_hit/frame_used/evicted_*/fault_count/final_res
// config  | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// each reference passes through a lookup state (parallel page compare over all frames
// plus the rank tree that picks the oldest frame) and a commit state (rank ageing,
// frame write, fault count, result register load)
// a new reference is taken in the commit state, so back-to-back references overlap: the
// next one is accepted while the last one commits, as long as the result side keeps up
// a stalled result holds the block in its commit state until the slot is free
// synchronous active-low reset empties the frame table and clears the fault count
module lru_page_replacement_unit
  import lrupr_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // reference transactions
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [PAGE_ID_W-1:0]    in_page_id,
  input  logic                    in_last_ref,
  // result transactions
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_hit,
  output logic [FRAME_USED_W-1:0] out_frame_used,
  output logic                    out_evicted_valid,
  output logic [PAGE_ID_W-1:0]    out_evicted_page,
  output logic [FAULT_W-1:0]      out_fault_count,
  output logic                    out_final_res,
  // register port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [APB_ADDR_W-1:0]   paddr,
  input  logic [APB_DATA_W-1:0]   pwdata,
  output logic [APB_DATA_W-1:0]   prdata,
  output logic                    pready
);

  lrupr_cmd_t       cmd;
  logic [CFG_W-1:0] frames_in_use_r;
  logic             reg_sel;

  // register index is the word address; only index 0 exists
  assign reg_sel = (paddr[APB_ADDR_W-1] == REG_FRAMES_IN_USE);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_in_use_r <= CFG_FRAMES_RST;
    end else if (psel && penable && pwrite && reg_sel) begin
      frames_in_use_r <= pwdata[CFG_W-1:0];
    end
  end

  // read back, unmapped addresses read zero
  assign prdata = reg_sel ? APB_DATA_W'(frames_in_use_r) : '0;

  lrupr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  lrupr_dp #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .frames_in_use     (frames_in_use_r),
    .in_page_id        (in_page_id),
    .in_last_ref       (in_last_ref),
    .out_hit           (out_hit),
    .out_frame_used    (out_frame_used),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_count   (out_fault_count),
    .out_final_res     (out_final_res)
  );

endmodule

// ----- rtl/core/lrupr_ctrl.sv -----
`timescale 1ns / 1ps
module lrupr_ctrl
  import lrupr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output lrupr_cmd_t cmd
);

  lrupr_state_t state_r, state_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic         can_load;
  logic         accept;

  // output slot free or being emptied this cycle
  assign can_load = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_LOOK;
      end
      ST_LOOK: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (can_load) state_nxt = in_valid ? ST_LOOK : ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    cmd.decide  = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_LOOK: begin
        cmd.decide = 1'b1;
      end
      ST_UPD: begin
        in_stall   = !can_load;
        cmd.commit = can_load;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
    accept      = in_valid && !in_stall;
    cmd.capture = accept;
  end

  always_comb begin
    if (cmd.commit)      out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else                 out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/core/lrupr_dp.sv -----
`timescale 1ns / 1ps
module lrupr_dp
  import lrupr_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lrupr_cmd_t              cmd,
  input  logic [CFG_W-1:0]        frames_in_use,
  input  logic [PAGE_ID_W-1:0]    in_page_id,
  input  logic                    in_last_ref,
  output logic                    out_hit,
  output logic [FRAME_USED_W-1:0] out_frame_used,
  output logic                    out_evicted_valid,
  output logic [PAGE_ID_W-1:0]    out_evicted_page,
  output logic [FAULT_W-1:0]      out_fault_count,
  output logic                    out_final_res
);

  localparam int FIDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int RANK_W = FIDX_W;
  localparam int TREE_N = 1 << FIDX_W;
  localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
  localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam logic [RANK_W-1:0] RANK_TOP = RANK_W'(MAX_FRAMES - 1);

  // frame table
  logic [PAGE_BITS-1:0] frame_page_r [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] frame_valid_r;
  logic [RANK_W-1:0]    rank_r [MAX_FRAMES];
  logic [FAULT_W-1:0]   faults_r, faults_nxt;

  // captured reference
  logic [PAGE_BITS-1:0] page_r;
  logic                 last_r;

  // lookup decision
  logic                 dec_hit_r, dec_empty_r;
  logic [FIDX_W-1:0]    dec_f_r;
  logic [RANK_W-1:0]    dec_limit_r;
  logic [PAGE_BITS-1:0] ev_page_r;

  // result register
  logic                    res_hit_r, res_ev_valid_r, res_final_r;
  logic [FRAME_USED_W-1:0] res_frame_r;
  logic [PAGE_ID_W-1:0]    res_ev_page_r;

  logic [CMP_W-1:0]      cfg_x, n_eff;
  logic [MAX_FRAMES-1:0] active, match_vec, empty_vec;
  logic [FIDX_W-1:0]     hit_f, empty_f, victim_f, dec_f;
  logic                  any_hit, any_empty;
  logic [RANK_W-1:0]     victim_rank, dec_limit;
  logic [RANK_W-1:0]     tr_rank [FIDX_W+1][TREE_N];
  logic [FIDX_W-1:0]     tr_idx  [FIDX_W+1][TREE_N];
  logic [MAX_FRAMES-1:0] age_vec;

  // active frame count, zero reads as one, clipped to the built size
  always_comb begin
    cfg_x = CMP_W'(frames_in_use);
    if (cfg_x == '0)                      n_eff = CMP_W'(1);
    else if (cfg_x > CMP_W'(MAX_FRAMES))  n_eff = CMP_W'(MAX_FRAMES);
    else                                  n_eff = cfg_x;
    for (int j = 0; j < MAX_FRAMES; j++) begin
      active[j]    = CMP_W'(j) < n_eff;
      match_vec[j] = active[j] && frame_valid_r[j] && (frame_page_r[j] == page_r);
      empty_vec[j] = active[j] && !frame_valid_r[j];
    end
  end

  // lowest-index hit and lowest-index empty frame
  always_comb begin
    hit_f   = '0;
    empty_f = '0;
    for (int j = MAX_FRAMES - 1; j >= 0; j--) begin
      if (match_vec[j]) hit_f   = FIDX_W'(j);
      if (empty_vec[j]) empty_f = FIDX_W'(j);
    end
    any_hit   = |match_vec;
    any_empty = |empty_vec;
  end

  // oldest active frame, lower index wins a tie
  always_comb begin
    for (int l = 0; l <= FIDX_W; l++) begin
      for (int k = 0; k < TREE_N; k++) begin
        tr_rank[l][k] = '0;
        tr_idx[l][k]  = '0;
      end
    end
    for (int k = 0; k < TREE_N; k++) begin
      tr_idx[0][k] = FIDX_W'(k);
      if (k < MAX_FRAMES) begin
        if (active[k]) tr_rank[0][k] = rank_r[k];
      end
    end
    for (int l = 0; l < FIDX_W; l++) begin
      for (int k = 0; k < (TREE_N >> (l + 1)); k++) begin
        if (tr_rank[l][2*k+1] > tr_rank[l][2*k]) begin
          tr_rank[l+1][k] = tr_rank[l][2*k+1];
          tr_idx[l+1][k]  = tr_idx[l][2*k+1];
        end else begin
          tr_rank[l+1][k] = tr_rank[l][2*k];
          tr_idx[l+1][k]  = tr_idx[l][2*k];
        end
      end
    end
    victim_f    = tr_idx[FIDX_W][0];
    victim_rank = tr_rank[FIDX_W][0];
  end

  always_comb begin
    if (any_hit) begin
      dec_f     = hit_f;
      dec_limit = rank_r[hit_f];
    end else if (any_empty) begin
      dec_f     = empty_f;
      dec_limit = '0;
    end else begin
      dec_f     = victim_f;
      dec_limit = victim_rank;
    end
  end

  // frames that age by one on commit
  always_comb begin
    for (int j = 0; j < MAX_FRAMES; j++) begin
      age_vec[j] = active[j] && frame_valid_r[j] && (FIDX_W'(j) != dec_f_r) &&
                   (dec_empty_r || (rank_r[j] < dec_limit_r)) &&
                   (rank_r[j] != RANK_TOP);
    end
    if (!dec_hit_r && (faults_r != '1)) faults_nxt = faults_r + FAULT_W'(1);
    else                                faults_nxt = faults_r;
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      page_r <= PAGE_BITS'(in_page_id);
      last_r <= in_last_ref;
    end
    if (cmd.decide) begin
      dec_hit_r   <= any_hit;
      dec_empty_r <= !any_hit && any_empty;
      dec_f_r     <= dec_f;
      dec_limit_r <= dec_limit;
      ev_page_r   <= frame_page_r[victim_f];
    end
    if (cmd.commit) begin
      if (!dec_hit_r) frame_page_r[dec_f_r] <= page_r;
      res_hit_r      <= dec_hit_r;
      res_frame_r    <= FRAME_USED_W'(dec_f_r);
      res_ev_valid_r <= !dec_hit_r && !dec_empty_r;
      res_ev_page_r  <= (!dec_hit_r && !dec_empty_r) ? PAGE_ID_W'(ev_page_r) : '0;
      res_final_r    <= last_r;
    end
  end

  // table state with defined reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_valid_r <= '0;
      faults_r      <= '0;
      for (int j = 0; j < MAX_FRAMES; j++) rank_r[j] <= '0;
    end else if (cmd.commit) begin
      for (int j = 0; j < MAX_FRAMES; j++) begin
        if (age_vec[j]) rank_r[j] <= rank_r[j] + RANK_W'(1);
      end
      rank_r[dec_f_r]        <= '0;
      frame_valid_r[dec_f_r] <= 1'b1;
      faults_r               <= faults_nxt;
    end
  end

  assign out_hit           = res_hit_r;
  assign out_frame_used    = res_frame_r;
  assign out_evicted_valid = res_ev_valid_r;
  assign out_evicted_page  = res_ev_page_r;
  assign out_fault_count   = faults_r;
  assign out_final_res     = res_final_r;

endmodule

// ----- rtl/core/lrupr_chk.sv -----
`timescale 1ns / 1ps
module lrupr_chk
  import lrupr_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic                    out_hit,
  input logic [FRAME_USED_W-1:0] out_frame_used,
  input logic                    out_evicted_valid,
  input logic [PAGE_ID_W-1:0]    out_evicted_page,
  input logic [FAULT_W-1:0]      out_fault_count
);

  // held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_frame_used) &&
      $stable(out_hit) && $stable(out_evicted_page) && $stable(out_fault_count))
    else $error("stalled result changed");

  // lookup cycle follows every accepted reference
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("reference accepted during lookup");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_evicted_valid)
    else $error("eviction reported on a hit");

  a_evict_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_evicted_valid |-> out_evicted_page == '0)
    else $error("evicted page not zero without eviction");

  a_fault_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_fault_count != '0)
    else $error("fault count zero after a page fault");

endmodule

bind lru_page_replacement_unit lrupr_chk u_lrupr_chk (.*);

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import lrupr_pkg::*;

  // run length guard, far above the slowest legal run
  localparam int LIMIT_CYCLES = 400000;
  // cycles left for the result path to settle after the last result
  localparam int TAIL_CYCLES  = 16;
  localparam int DIR_N        = 20;
  localparam int PHASE_N      = 16;
  localparam int PLAN_N       = 12;
  localparam int PHASE_REFS   = 80;
  localparam int POOL_MAX     = 20;
  localparam int HOLD_CYCLES  = 80;
  localparam logic [APB_ADDR_W-1:0] FRAMES_ADDR = APB_ADDR_W'(4 * int'(REG_FRAMES_IN_USE));

  // one result transaction as the block reports it
  typedef struct packed {
    logic                    hit;
    logic [FRAME_USED_W-1:0] frame;
    logic                    ev_valid;
    logic [PAGE_ID_W-1:0]    ev_page;
    logic [FAULT_W-1:0]      faults;
    logic                    final_res;
  } lru_outcome_t;

  // directed row: reference plus an optional hand-written outcome
  typedef struct packed {
    logic [PAGE_ID_W-1:0] page;
    logic                 last;
    logic                 typed;
    lru_outcome_t         outcome;
  } dir_row_t;

  // opening string, traced by hand with the reset frame count of four:
  // fill all four frames with one hit among the fills, then two evictions (the second one evicts page zero)
  // later rows lean on the predictor
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    {16'h0000, 1'b0, 1'b1, {1'b0, 4'd0, 1'b0, 16'h0000, 32'd1, 1'b0}},
    {16'hFFFF, 1'b0, 1'b1, {1'b0, 4'd1, 1'b0, 16'h0000, 32'd2, 1'b0}},
    {16'h0000, 1'b0, 1'b1, {1'b1, 4'd0, 1'b0, 16'h0000, 32'd2, 1'b0}},
    {16'h1234, 1'b0, 1'b1, {1'b0, 4'd2, 1'b0, 16'h0000, 32'd3, 1'b0}},
    {16'h8000, 1'b0, 1'b1, {1'b0, 4'd3, 1'b0, 16'h0000, 32'd4, 1'b0}},
    {16'h5555, 1'b0, 1'b1, {1'b0, 4'd1, 1'b1, 16'hFFFF, 32'd5, 1'b0}},
    {16'hAAAA, 1'b1, 1'b1, {1'b0, 4'd0, 1'b1, 16'h0000, 32'd6, 1'b1}},
    {16'h5555, 1'b0, 1'b0, 55'd0},
    {16'hAAAA, 1'b0, 1'b0, 55'd0},
    {16'hAAAA, 1'b0, 1'b0, 55'd0},
    {16'h0001, 1'b0, 1'b0, 55'd0},
    {16'hFFFE, 1'b0, 1'b0, 55'd0},
    {16'h7FFF, 1'b0, 1'b0, 55'd0},
    {16'h1234, 1'b0, 1'b0, 55'd0},
    {16'h8000, 1'b0, 1'b0, 55'd0},
    {16'hFFFF, 1'b1, 1'b0, 55'd0},
    {16'h00FF, 1'b0, 1'b0, 55'd0},
    {16'hFF00, 1'b0, 1'b0, 55'd0},
    {16'h00FF, 1'b0, 1'b0, 55'd0},
    {16'h0F0F, 1'b1, 1'b0, 55'd0}
  };

  // frame counts per phase: minimum, maximum, zero, over-range, junk upper bits,
  // just above the built size, then shrink and regrow to leave stale frames behind
  localparam logic [31:0] CFG_PLAN [PLAN_N] = '{
    32'd1, 32'd16, 32'd0, 32'd31, 32'hFFFF_FFE3, 32'd17,
    32'd8, 32'd2, 32'd16, 32'd5, 32'd12, 32'd1
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [PAGE_ID_W-1:0]    in_page_id = '0;
  logic                    in_last_ref = 1'b0;

  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    out_hit;
  logic [FRAME_USED_W-1:0] out_frame_used;
  logic                    out_evicted_valid;
  logic [PAGE_ID_W-1:0]    out_evicted_page;
  logic [FAULT_W-1:0]      out_fault_count;
  logic                    out_final_res;

  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]   paddr = '0;
  logic [APB_DATA_W-1:0]   pwdata = '0;
  logic [APB_DATA_W-1:0]   prdata;
  logic                    pready;

  // shadow of the frame table, kept in step with every accepted reference
  logic [PAGE_ID_W-1:0]    shadow_page [MAX_FRAMES_DEF];
  logic                    shadow_valid [MAX_FRAMES_DEF];
  logic [3:0]              shadow_rank [MAX_FRAMES_DEF];
  logic [FAULT_W-1:0]      fault_total = '0;
  logic [CFG_W-1:0]        frames_cfg = CFG_FRAMES_RST;

  lru_outcome_t            expected_outcomes [$];

  int  cycles = 0;
  int  err_count = 0;
  int  sent_refs = 0;
  int  sender_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  hold_left = 0;
  bit  hold_off_req = 1'b0;

  lru_page_replacement_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_page_id        (in_page_id),
    .in_last_ref       (in_last_ref),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_frame_used    (out_frame_used),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_count   (out_fault_count),
    .out_final_res     (out_final_res),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // zero means one frame, anything past the built size saturates
  function automatic int live_frames();
    if (frames_cfg == '0) return 1;
    if (frames_cfg > MAX_FRAMES_DEF) return MAX_FRAMES_DEF;
    return int'(frames_cfg);
  endfunction

  // make frame f most recent; live valid frames newer than limit age by one,
  // and an age never passes the oldest rank
  function automatic void age_ranks(input int f, input logic [31:0] limit, input int n);
    int j;
    for (j = 0; j < n; j++) begin
      if (j != f && shadow_valid[j] && {28'd0, shadow_rank[j]} < limit) begin
        if (shadow_rank[j] < 4'(MAX_FRAMES_DEF - 1)) shadow_rank[j]++;
      end
    end
    shadow_rank[f] = '0;
  endfunction

  // lookup, fill or replace, and return what the block should report
  function automatic lru_outcome_t lru_lookup(input logic [PAGE_ID_W-1:0] page,
                                              input logic last);
    lru_outcome_t r;
    int           n;
    int           j;
    int           f;
    bit           found;
    bit           empty;
    logic [3:0]   oldest;
    r      = '0;
    n      = live_frames();
    f      = 0;
    found  = 1'b0;
    empty  = 1'b0;
    oldest = '0;
    for (j = 0; j < n; j++) begin
      if (!found && shadow_valid[j] && shadow_page[j] == page) begin
        found = 1'b1;
        f     = j;
      end
    end
    if (found) begin
      age_ranks(f, {28'd0, shadow_rank[f]}, n);
    end else begin
      for (j = 0; j < n; j++) begin
        if (!empty && !shadow_valid[j]) begin
          empty = 1'b1;
          f     = j;
        end
      end
      if (!empty) begin
        // oldest frame wins, lowest index on a tie
        f = 0;
        for (j = 0; j < n; j++) begin
          if (shadow_rank[j] > oldest) begin
            oldest = shadow_rank[j];
            f      = j;
          end
        end
        r.ev_valid = 1'b1;
        r.ev_page  = shadow_page[f];
        age_ranks(f, {28'd0, oldest}, n);
      end else begin
        age_ranks(f, 32'hFFFF_FFFF, n);
      end
      shadow_page[f]  = page;
      shadow_valid[f] = 1'b1;
      if (fault_total != {FAULT_W{1'b1}}) fault_total++;
    end
    r.hit       = found;
    r.frame     = f[FRAME_USED_W-1:0];
    r.faults    = fault_total;
    r.final_res = last;
    return r;
  endfunction

  // offer one reference; valid stays high into the next call unless a gap is drawn
  task automatic send_ref(input logic [PAGE_ID_W-1:0] page, input logic last,
                          input logic typed, input lru_outcome_t hand_outcome);
    lru_outcome_t predicted;
    // idling pattern moves on with the number of references sent
    if (sent_refs < 433) begin
      sender_idle_pct = 7;
      recv_idle_pct   = 70;
    end else if (sent_refs < 866) begin
      sender_idle_pct = 70;
      recv_idle_pct   = 7;
    end else begin
      sender_idle_pct = 0;
      recv_idle_pct   = 0;
    end
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
    end
    in_valid    <= 1'b1;
    in_page_id  <= page;
    in_last_ref <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // transaction taken at this edge
    predicted = lru_lookup(page, last);
    expected_outcomes.push_back(typed ? hand_outcome : predicted);
    sent_refs++;
  endtask

  // drop valid and wait until every reference has reported back
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= FRAMES_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    frames_cfg = value[CFG_W-1:0];
  endtask

  task automatic cfg_check(input logic [APB_DATA_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= FRAMES_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want) begin
      err_count++;
      if (err_count <= 10)
        $display("frames_in_use readback: expected %0h, got %0h", want, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // reference strings over a small pool of pages, sized to the live frame count so
  // hits, fills and evictions all turn up; some fully random pages as noise
  task automatic run_strings(input int count, input int phase);
    logic [PAGE_ID_W-1:0] pool [POOL_MAX];
    logic [PAGE_ID_W-1:0] page;
    int                   pool_n;
    int                   str_left;
    int                   k;
    pool_n = live_frames() + 1 + $urandom_range(0, 3);
    if (pool_n > POOL_MAX) pool_n = POOL_MAX;
    for (k = 0; k < pool_n; k++) pool[k] = PAGE_ID_W'($urandom);
    str_left = $urandom_range(3, 40);
    for (k = 0; k < count; k++) begin
      // long result hold-off while references keep coming, fills the block
      if (k == 40 && (phase == 6 || phase == 13)) hold_off_req = 1'b1;
      if ($urandom_range(0, 99) < 15) page = PAGE_ID_W'($urandom);
      else page = pool[$urandom_range(0, pool_n - 1)];
      str_left--;
      send_ref(page, str_left == 0, 1'b0, '0);
      if (str_left == 0) str_left = $urandom_range(3, 40);
    end
  endtask

  // result side: check each transaction against the oldest expectation,
  // then pick the stall for the next cycle
  always @(posedge clk) begin
    lru_outcome_t got;
    lru_outcome_t want;
    if (out_valid && !out_stall) begin
      got = {out_hit, out_frame_used, out_evicted_valid, out_evicted_page,
             out_fault_count, out_final_res};
      if (expected_outcomes.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("result with nothing outstanding: %h", got);
      end else begin
        want = expected_outcomes.pop_front();
        if (got.hit !== want.hit || got.frame !== want.frame ||
            got.ev_valid !== want.ev_valid || got.ev_page !== want.ev_page ||
            got.faults !== want.faults || got.final_res !== want.final_res) begin
          err_count++;
          if (err_count <= 10) begin
            $display("mismatch: exp hit=%0b frame=%0d ev=%0b/%h faults=%0d final=%0b",
                     want.hit, want.frame, want.ev_valid, want.ev_page, want.faults,
                     want.final_res);
            $display("          got hit=%0b frame=%0d ev=%0b/%h faults=%0d final=%0b",
                     got.hit, got.frame, got.ev_valid, got.ev_page, got.faults,
                     got.final_res);
          end
        end
      end
    end
    if (hold_off_req) begin
      hold_left    = HOLD_CYCLES;
      hold_off_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // stimulus
  initial begin
    int          i;
    int          p;
    logic [31:0] value;
    for (i = 0; i < MAX_FRAMES_DEF; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_rank[i]  = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset value of the frame count, then the hand-checked opening string
    cfg_check({{(APB_DATA_W-CFG_W){1'b0}}, CFG_FRAMES_RST});
    for (i = 0; i < DIR_N; i++)
      send_ref(DIR_TAB[i].page, DIR_TAB[i].last, DIR_TAB[i].typed, DIR_TAB[i].outcome);

    // phases at different frame counts, no reset in between so stale frames
    // and equal ranks carry across count changes
    for (p = 0; p < PHASE_N; p++) begin
      settle();
      if (p < PLAN_N) value = CFG_PLAN[p];
      else value = $urandom_range(0, 31);
      cfg_write(value);
      cfg_check({{(APB_DATA_W-CFG_W){1'b0}}, value[CFG_W-1:0]});
      run_strings(PHASE_REFS, p);
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
